// ===== src/ttoi_pkg.sv =====
package ttoi_pkg;

	// Number of digit symbol slots held by the two symbol registers.
	localparam int SYMBOLS = 16;
	// Largest base the block supports.
	localparam int MAX_RADIX = 16;
	localparam int USABLE_LIMIT = (MAX_RADIX < SYMBOLS) ? MAX_RADIX : SYMBOLS;
	localparam int DIGIT_W = $clog2(SYMBOLS);
	localparam int RADIX_W = 5;
	localparam int VALUE_W = 32;
	localparam int QDEPTH = 2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd0;
	localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd1;
	localparam logic [1:0] REG_RADIX        = 2'd2;

	// Characters with a fixed meaning.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [SYMBOLS-1:0][7:0] sym;
		logic [RADIX_W-1:0]      radix;
		logic                    ok;
	} cfg_t;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		logic               first;
		logic               ok;
		logic               digit_vld;
		logic [DIGIT_W-1:0] digit;
		logic               is_space;
		logic               is_sign;
		logic               is_minus;
		logic [RADIX_W-1:0] radix;
	} entry_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

// ===== src/text_to_integer_custom_radix.sv =====
// Streaming parser of a signed integer written in a configurable digit alphabet.
//
// Input channel (s_tvalid/s_tready/s_tdata/s_tuser): one character per transfer;
// s_tuser marks the first character of a new string and clears the parse state.
// Output channel (m_tvalid/m_tready/m_tdata/m_tuser): exactly one result per input
// character, holding the signed value parsed so far, the done flag and the
// alphabet check. Leading whitespace is skipped, then a run of signs is read,
// then digits are accumulated until the first character that is not a digit.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 and 1 load
// the symbol bytes 0..7 and 8..15, index 2 the radix. cfg_ready is always high;
// write only while no character is in flight.
//
// Throughput is one character per cycle while m_tready is high; the limit is the
// accumulator update, one 32 by 5 bit multiply-add per cycle in the back end. A
// two-entry queue between classifier and accumulator takes each transfer, and its
// head is loaded into the output register; when m_tready is low that register
// holds, the queue fills and s_tready falls only once both entries are taken.
// Reset clears the configuration and the parse state, empties the queue and drops
// the output valid; the alphabet is then invalid and every result reads zero until
// a valid alphabet is loaded.
module text_to_integer_custom_radix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tuser,   // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value, signed
	output logic [1:0]  m_tuser,   // [0] done_res, [1] alphabet_ok
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import ttoi_pkg::*;

	cfg_t   cfg;
	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   pop;
	logic   q_full;
	logic   q_not_empty;

	// Configuration writes are always taken; the alphabet check follows the
	// registers directly, so a character accepted after a write sees it.
	assign cfg_ready = 1'b1;

	ttoi_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// The front end classifies each character as digit, whitespace or sign.
	ttoi_front u_front (
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.ch         (s_tdata),
		.first      (s_tuser),
		.cfg        (cfg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ttoi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head       (head)
	);

	// The back end runs the parse state and drives the output register.
	ttoi_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_user    (m_tuser)
	);

endmodule

// ===== src/ttoi_cfg.sv =====
module ttoi_cfg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [63:0]      wr_data,
	output ttoi_pkg::cfg_t   cfg
);
	import ttoi_pkg::*;

	logic [63:0]        sym_low_q;
	logic [63:0]        sym_high_q;
	logic [RADIX_W-1:0] radix_q;
	logic               bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_low_q  <= '0;
			sym_high_q <= '0;
			radix_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SYMBOLS_LOW:  sym_low_q  <= wr_data;
				REG_SYMBOLS_HIGH: sym_high_q <= wr_data;
				REG_RADIX:        radix_q    <= wr_data[RADIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sym   = {sym_high_q, sym_low_q};
	assign cfg.radix = radix_q;

	// A symbol in use may not be NUL, whitespace or a sign, and may not repeat.
	always_comb begin
		bad = (radix_q < RADIX_W'(2)) || (radix_q > RADIX_W'(USABLE_LIMIT));
		for (int i = 0; i < SYMBOLS; i++) begin
			if (RADIX_W'(i) < radix_q) begin
				if (cfg.sym[i] == CH_NUL || is_space(cfg.sym[i]) ||
				    cfg.sym[i] == CH_PLUS || cfg.sym[i] == CH_MINUS)
					bad = 1'b1;
				for (int j = i + 1; j < SYMBOLS; j++) begin
					if (RADIX_W'(j) < radix_q && cfg.sym[i] == cfg.sym[j])
						bad = 1'b1;
				end
			end
		end
	end

	assign cfg.ok = !bad;

endmodule

// ===== src/ttoi_front.sv =====
module ttoi_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       ch,
	input  logic             first,
	input  ttoi_pkg::cfg_t   cfg,
	input  logic             q_full,
	output logic             push,
	output ttoi_pkg::entry_t push_entry
);
	import ttoi_pkg::*;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		push_entry.first     = first;
		push_entry.ok        = cfg.ok;
		push_entry.digit_vld = 1'b0;
		push_entry.digit     = '0;
		// Highest slot first so the lowest matching slot wins.
		for (int i = SYMBOLS - 1; i >= 0; i--) begin
			if (cfg.ok && RADIX_W'(i) < cfg.radix && cfg.sym[i] == ch) begin
				push_entry.digit_vld = 1'b1;
				push_entry.digit     = DIGIT_W'(i);
			end
		end
		push_entry.is_space = is_space(ch);
		push_entry.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		push_entry.is_minus = (ch == CH_MINUS);
		push_entry.radix    = cfg.radix;
	end

endmodule

// ===== src/ttoi_queue.sv =====
module ttoi_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ttoi_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output ttoi_pkg::entry_t head
);
	import ttoi_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);

	entry_t             mem_q [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== src/ttoi_back.sv =====
module ttoi_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  ttoi_pkg::entry_t    head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_data,
	output logic [1:0]          out_user
);
	import ttoi_pkg::*;

	localparam logic [1:0] PH_SKIP   = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [1:0]         phase_q;
	logic               neg_q;
	logic [VALUE_W-1:0] acc_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic               done_q;
	logic               ok_q;

	logic [1:0]         phase_in, phase_nx;
	logic               neg_in, neg_nx;
	logic [VALUE_W-1:0] acc_in, acc_nx, val_nx;

	assign pop = q_not_empty && (!out_valid_q || out_ready);

	always_comb begin
		phase_in = head.first ? PH_SKIP : phase_q;
		neg_in   = head.first ? 1'b0 : neg_q;
		acc_in   = head.first ? '0 : acc_q;
		phase_nx = phase_in;
		neg_nx   = neg_in;
		acc_nx   = acc_in;
		if (phase_in != PH_DONE) begin
			if (head.digit_vld) begin
				acc_nx   = VALUE_W'(acc_in * VALUE_W'(head.radix)) + VALUE_W'(head.digit);
				phase_nx = PH_DIGITS;
			end else if (phase_in == PH_SKIP && head.is_space) begin
				phase_nx = PH_SKIP;
			end else if ((phase_in == PH_SKIP || phase_in == PH_SIGN) && head.is_sign) begin
				neg_nx   = neg_in ^ head.is_minus;
				phase_nx = PH_SIGN;
			end else begin
				phase_nx = PH_DONE;
			end
		end
		if (!head.ok)
			val_nx = '0;
		else if (neg_nx)
			val_nx = VALUE_W'(0) - acc_nx;
		else
			val_nx = acc_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SKIP;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_nx;
				neg_q   <= neg_nx;
				acc_q   <= acc_nx;
			end
			if (pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= val_nx;
			done_q  <= (phase_nx == PH_DONE);
			ok_q    <= head.ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = value_q;
	assign out_user  = {ok_q, done_q};

	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (value_q == '0))
		else $error("nonzero value with invalid alphabet");
	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.first && phase_q == PH_DONE) |=> (phase_q == PH_DONE && done_q))
		else $error("parse left done without a new string");
	a_done_matches: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (done_q == (phase_q == PH_DONE)))
		else $error("done flag out of step with parse phase");

endmodule
